// ===== sv/mcgr_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-channel gain ramp package
// Shared widths, codes and types for the ramp table and its sequencer.
// ----------------------------------------------------------------------------
package mcgr_pkg;

  localparam int CHANNELS_DEF = 32;
  localparam int DATA_W       = 16;
  localparam int CHAN_W       = 5;
  localparam int STEP_W       = $clog2(DATA_W);

  typedef enum logic {
    FUNC_SET  = 1'b0,
    FUNC_TICK = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } state_e;

  // One row of the ramp table.
  typedef struct packed {
    logic                     active;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] start;
    logic signed [DATA_W-1:0] tgt;
    logic        [DATA_W-1:0] count;
    logic        [DATA_W-1:0] length;
  } ramp_entry_t;

endpackage

// ===== sv/multi_channel_gain_ramp_top.sv =====
// ----------------------------------------------------------------------------
// Multi-channel gain ramp generator
// A table of independent linear ramps, one row per channel, with a bit-serial
// multiply and divide unit that interpolates the value of a running ramp.
// ----------------------------------------------------------------------------
// Each input transaction either starts a ramp on a channel (the present value
// becomes the start, and the target and the duration in ticks are stored) or
// advances a channel by one tick. Every input transaction yields exactly one
// output transaction with the channel, its signed Q8.8 value and its active
// flag. The block handles one transaction at a time. A set, a tick on an idle
// channel, a tick that ends a ramp and a channel beyond CHANNELS load the row
// and then hand it to the output register, and the next input transaction is
// accepted once the result has gone to the output register. A tick that
// interpolates also forms the product (target - start) * count one multiplier
// bit per cycle over 16 steps, then the quotient by the duration one bit per
// cycle over another 16 steps, both in the same 32-bit shift register, and
// adds the quotient to the start in a final state. The result sits in an
// output register, so a new input transaction can be accepted while the
// previous result is still stalled. The table is a memory with one read and
// one write port; per-row valid bits cleared by reset make every row read as
// zero until it is first written, so no clearing pass is needed after reset.
module multi_channel_gain_ramp_top #(
  parameter int CHANNELS = mcgr_pkg::CHANNELS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input channel.
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               func_i,
  input  logic        [mcgr_pkg::CHAN_W-1:0] channel_i,
  input  logic signed [mcgr_pkg::DATA_W-1:0] target_i,
  input  logic        [mcgr_pkg::DATA_W-1:0] duration_i,
  // Output channel.
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic        [mcgr_pkg::CHAN_W-1:0] channel_out_o,
  output logic signed [mcgr_pkg::DATA_W-1:0] value_o,
  output logic                               active_o
);
  import mcgr_pkg::*;

  localparam int IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ExtW = (IdxW > CHAN_W) ? IdxW : CHAN_W;
  localparam int CmpW = 9;

  state_e state_q, state_d;

  // Latched input transaction.
  func_e                    func_q;
  logic        [CHAN_W-1:0] chan_q;
  logic signed [DATA_W-1:0] target_q;
  logic        [DATA_W-1:0] dur_q;

  // Ramp table and its valid bits.
  ramp_entry_t mem_q [CHANNELS];
  logic [CHANNELS-1:0] vld_q;
  ramp_entry_t rd_q;
  logic        rd_vld_q;

  // Working row and serial arithmetic registers.
  ramp_entry_t       ent_q;
  logic              wr_q;
  logic              neg_q;
  logic [DATA_W-1:0] mcand_q;
  logic [DATA_W-1:0] mplier_q;
  logic [2*DATA_W-1:0] acc_q;
  logic [STEP_W-1:0] step_q;

  // Output register.
  logic                     out_valid_q;
  logic        [CHAN_W-1:0] out_chan_q;
  logic signed [DATA_W-1:0] out_val_q;
  logic                     out_act_q;

  logic              accept;
  logic              out_load;
  logic [ExtW-1:0]   ch_in_ext;
  logic [ExtW-1:0]   ch_q_ext;
  logic [IdxW-1:0]   rd_idx;
  logic [IdxW-1:0]   wr_idx;
  logic              in_range;
  ramp_entry_t       entry;
  ramp_entry_t       load_ent;
  logic              load_wr;
  logic              load_mul;
  logic [DATA_W-1:0] cnt_inc;
  logic [DATA_W:0]   delta;
  logic [DATA_W:0]   delta_mag;
  logic [DATA_W:0]   mul_sum;
  logic [DATA_W:0]   div_rem;
  logic [DATA_W:0]   div_trial;
  logic              div_bit;
  logic [DATA_W:0]   q_signed;
  logic [DATA_W+1:0] fin_sum;
  logic              last_step;

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  assign ch_in_ext = ExtW'(channel_i);
  assign ch_q_ext  = ExtW'(chan_q);
  assign rd_idx    = ch_in_ext[IdxW-1:0];
  assign wr_idx    = ch_q_ext[IdxW-1:0];
  assign in_range  = CmpW'(chan_q) < CmpW'(CHANNELS);
  assign last_step = step_q == STEP_W'(DATA_W - 1);

  // A row that was never written reads as the reset value, all zero.
  assign entry   = rd_vld_q ? rd_q : '0;
  assign cnt_inc = entry.count + DATA_W'(1);

  // The difference spans 17 bits, but its magnitude never exceeds 16 bits.
  assign delta     = {entry.tgt[DATA_W-1], entry.tgt} - {entry.start[DATA_W-1], entry.start};
  assign delta_mag = delta[DATA_W] ? (~delta + (DATA_W+1)'(1)) : delta;

  // Decide what the item does once the row has been read.
  always_comb begin
    load_ent = entry;
    load_wr  = 1'b0;
    load_mul = 1'b0;
    if (!in_range) begin
      load_ent = '0;
    end else begin
      case (func_q)
        FUNC_SET: begin
          load_ent.start  = entry.value;
          load_ent.tgt    = target_q;
          load_ent.length = dur_q;
          load_ent.count  = '0;
          load_ent.active = 1'b1;
          load_wr         = 1'b1;
        end
        FUNC_TICK: begin
          if (entry.active) begin
            load_wr = 1'b1;
            if ((entry.length <= cnt_inc) || (cnt_inc == '0)) begin
              load_ent.value  = entry.tgt;
              load_ent.count  = '0;
              load_ent.length = '0;
              load_ent.active = 1'b0;
            end else begin
              load_ent.count = cnt_inc;
              load_mul       = 1'b1;
            end
          end
        end
        default: begin
          load_ent = entry;
        end
      endcase
    end
  end

  // Shift-right multiplier step: add the multiplicand into the upper half.
  assign mul_sum = {1'b0, acc_q[2*DATA_W-1:DATA_W]}
                 + (mplier_q[0] ? {1'b0, mcand_q} : '0);

  // Restoring divider step; the upper half holds the partial remainder.
  assign div_rem   = {acc_q[2*DATA_W-1:DATA_W], acc_q[DATA_W-1]};
  assign div_trial = div_rem - {1'b0, ent_q.length};
  assign div_bit   = div_rem >= {1'b0, ent_q.length};

  // Quotient magnitude with the sign of the difference, added to the start.
  assign q_signed = neg_q ? (~{1'b0, acc_q[DATA_W-1:0]} + (DATA_W+1)'(1))
                          : {1'b0, acc_q[DATA_W-1:0]};
  assign fin_sum  = {{2{ent_q.start[DATA_W-1]}}, ent_q.start} + {q_signed[DATA_W], q_signed};

  always_comb begin
    state_d    = state_q;
    in_stall_o = state_q != ST_IDLE;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_d = load_mul ? ST_MUL : ST_DONE;
      end
      ST_MUL: begin
        if (last_step) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (last_step) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Table memory: one registered read at acceptance, one write at the end.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= mem_q[rd_idx];
    end
    if (out_load && wr_q) begin
      mem_q[wr_idx] <= ent_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        rd_vld_q <= vld_q[rd_idx];
      end
      if (out_load && wr_q) begin
        vld_q[wr_idx] <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q   <= func_e'(func_i);
      chan_q   <= channel_i;
      target_q <= target_i;
      dur_q    <= duration_i;
    end
    case (state_q)
      ST_LOAD: begin
        ent_q    <= load_ent;
        neg_q    <= delta[DATA_W];
        mcand_q  <= delta_mag[DATA_W-1:0];
        mplier_q <= cnt_inc;
        acc_q    <= '0;
        step_q   <= '0;
      end
      ST_MUL: begin
        acc_q    <= {mul_sum, acc_q[DATA_W-1:1]};
        mplier_q <= mplier_q >> 1;
        step_q   <= step_q + STEP_W'(1);
      end
      ST_DIV: begin
        acc_q  <= {(div_bit ? div_trial[DATA_W-1:0] : div_rem[DATA_W-1:0]),
                   acc_q[DATA_W-2:0], div_bit};
        step_q <= step_q + STEP_W'(1);
      end
      ST_FIN: begin
        ent_q.value <= fin_sum[DATA_W-1:0];
      end
      default: begin
        step_q <= step_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
    end else if (state_q == ST_LOAD) begin
      wr_q <= load_wr;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_chan_q <= chan_q;
      out_val_q  <= ent_q.value;
      out_act_q  <= ent_q.active;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign channel_out_o = out_chan_q;
  assign value_o       = out_val_q;
  assign active_o      = out_act_q;

  // An accepted transaction stalls the input in the next cycle.
  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted on two consecutive cycles");

  // A result appears only from the final sequencer state.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result presented outside the final state");

  // A channel beyond the table reports a zero, idle result.
  a_out_of_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (CmpW'(channel_out_o) >= CmpW'(CHANNELS)) |-> (value_o == '0) && !active_o)
    else $error("out-of-range channel returned state");

  // The serial unit always starts its count from zero.
  a_step_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) && (state_d == ST_MUL) |=> (step_q == '0))
    else $error("serial step counter not cleared");

endmodule
